@@ design/wfq_scheduler_virtual_time_macros.svh @@
// ----------------------------------------------------------------------------
// WFQ scheduler assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef WFQ_SCHEDULER_VIRTUAL_TIME_MACROS_SVH
`define WFQ_SCHEDULER_VIRTUAL_TIME_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled in reset.
`define WFQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled in reset.
`define WFQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WFQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define WFQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ design/wfq_pkg.sv @@
// ----------------------------------------------------------------------------
// WFQ package
// Widths, codes, shared types and helper functions of the WFQ scheduler.
// ----------------------------------------------------------------------------
package wfq_pkg;

    localparam int NUM_CLASSES = 2;
    localparam int QUEUE_DEPTH = 1024;
    localparam int FRAC_BITS   = 32;
    localparam int WEIGHT_FRAC = 16;

    localparam int TIME_W   = 64;
    localparam int WEIGHT_W = 32;
    localparam int RATE_W   = 40;
    localparam int PORT_W   = 16;
    localparam int LIMIT_W  = 11;
    localparam int PROTO_W  = 8;
    localparam int SIZE_W   = 16;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 2;

    localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;
    localparam int SIZE_SHIFT = 3;  // bytes to bits

    localparam int CLS_W     = $clog2(NUM_CLASSES);
    localparam int ITER_W    = $clog2(NUM_CLASSES + 1);
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int RAM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int PKT_W     = SIZE_W + TAG_W;
    localparam int ENTRY_W   = TIME_W + PKT_W;

    localparam int SUM_W     = WEIGHT_W + CLS_W;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = SUM_W + MUL_B_W;
    localparam int P_W       = TIME_W + SUM_W;
    localparam int DEN_W     = WEIGHT_W + RATE_W;

    localparam int ADV_NUM_W = TIME_W + WEIGHT_FRAC;
    localparam int INC_NUM_W = SIZE_W + SIZE_SHIFT + FRAC_BITS + WEIGHT_FRAC;
    localparam int NUM_W     = (ADV_NUM_W > INC_NUM_W) ? ADV_NUM_W : INC_NUM_W;
    localparam int DIV_BITS  = 2;
    localparam int DIV_CYC   = (NUM_W + DIV_BITS - 1) / DIV_BITS;
    localparam int NUM_PW    = DIV_CYC * DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_CYC + 1);

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = RATE_W;

    localparam logic [WEIGHT_W-1:0] RST_WEIGHT = 32'd65536;
    localparam logic [RATE_W-1:0]   RST_RATE   = 40'd1000000;
    localparam logic [PORT_W-1:0]   RST_PORT   = 16'd10;
    localparam logic [LIMIT_W-1:0]  RST_LIMIT  = 11'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_WEIGHT  = 3'd0,
        CFG_SECOND_WEIGHT = 3'd1,
        CFG_LINK_RATE     = 3'd2,
        CFG_SPECIAL_PORT  = 3'd3,
        CFG_CLASS_LIMIT   = 3'd4
    } cfg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT = 2'd0,
        ST_DROP   = 2'd1,
        ST_DEQ    = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        B_IDLE,
        B_DQ_RD,
        B_DQ_CMP,
        B_DQ_DONE,
        B_EN_CHK,
        B_SCAN,
        B_ADV,
        B_ADV_DIV,
        B_SPAN0,
        B_SPAN1,
        B_SPAN2,
        B_DEL,
        B_DEN0,
        B_DEN1,
        B_DEN2,
        B_INC,
        B_INC_DIV,
        B_OUT
    } bstate_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] first_weight;
        logic [WEIGHT_W-1:0] second_weight;
        logic [RATE_W-1:0]   link_rate;
        logic [PORT_W-1:0]   special_port;
        logic [LIMIT_W-1:0]  class_limit;
    } cfg_t;

    typedef struct packed {
        logic              func;
        logic [CLS_W-1:0]  cls;
        logic [TIME_W-1:0] now_time;
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  tag;
    } cmd_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? '1 : s[TIME_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [CLS_W-1:0] c,
                                                    input logic [PTR_W-1:0] p);
        return ADDR_W'(c) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

@@ design/wfq_if.sv @@
// ----------------------------------------------------------------------------
// WFQ channel interfaces
// Valid/ready channels for packet requests, results and register writes.
// ----------------------------------------------------------------------------
interface wfq_in_if;
    import wfq_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [TIME_W-1:0]    now_time;
    logic [PROTO_W-1:0]   protocol;
    logic                 first_fragment;
    logic [PORT_W-1:0]    dest_port;
    logic [SIZE_W-1:0]    packet_size;
    logic [TAG_W-1:0]     packet_tag;
    modport source (output valid, func, now_time, protocol, first_fragment,
                    dest_port, packet_size, packet_tag, input ready);
    modport sink   (input valid, func, now_time, protocol, first_fragment,
                    dest_port, packet_size, packet_tag, output ready);
endinterface

interface wfq_out_if;
    import wfq_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic                 class_index;
    logic [TAG_W-1:0]     out_tag;
    logic [SIZE_W-1:0]    out_size;
    logic [TIME_W-1:0]    finish_tag;
    modport source (output valid, status, class_index, out_tag, out_size,
                    finish_tag, input ready);
    modport sink   (input valid, status, class_index, out_tag, out_size,
                    finish_tag, output ready);
endinterface

interface wfq_cfg_if;
    import wfq_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/wfq_ram.sv @@
// ----------------------------------------------------------------------------
// WFQ generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ design/wfq_div.sv @@
// ----------------------------------------------------------------------------
// WFQ divider
// Restoring divider, DIV_BITS quotient bits a cycle, saturating 64-bit result.
// ----------------------------------------------------------------------------
module wfq_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [wfq_pkg::NUM_PW-1:0] num,
    input  logic [wfq_pkg::DEN_W-1:0]  den,
    output logic                       done,
    output logic [wfq_pkg::TIME_W-1:0] quo
);
    import wfq_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [NUM_PW-1:0]    num_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [NUM_PW-1:0]    q_reg;
    logic [DEN_W:0]       rem_next;
    logic [NUM_PW-1:0]    num_next;
    logic [NUM_PW-1:0]    q_next;

    // shift in DIV_BITS numerator bits one at a time, subtract where it fits
    always_comb
    begin
        rem_next = {1'b0, rem_reg};
        num_next = num_reg;
        q_next   = q_reg;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            rem_next = {rem_next[DEN_W-1:0], num_next[NUM_PW-1]};
            num_next = num_next << 1;
            if (rem_next >= {1'b0, den_reg})
            begin
                rem_next = rem_next - {1'b0, den_reg};
                q_next   = {q_next[NUM_PW-2:0], 1'b1};
            end
            else
            begin
                q_next   = {q_next[NUM_PW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_CYC);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next[DEN_W-1:0];
            q_reg   <= q_next;
        end
    end

    assign done = done_reg;
    assign quo  = (den_reg == '0) ? '1 :
                  (|q_reg[NUM_PW-1:TIME_W]) ? '1 : q_reg[TIME_W-1:0];
endmodule

@@ design/wfq_front.sv @@
// ----------------------------------------------------------------------------
// WFQ front end
// Accept requests, classify enqueues, hold them in a short command queue.
// ----------------------------------------------------------------------------
module wfq_front (
    input  logic          clk,
    input  logic          rst_n,
    wfq_in_if.sink        in_ch,
    input  wfq_pkg::cfg_t cfg,
    output logic          cmd_valid,
    output wfq_pkg::cmd_t cmd,
    input  logic          cmd_pop
);
    import wfq_pkg::*;

    cmd_t                  q_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0] cnt_reg;
    logic                  push;
    logic                  hit;
    cmd_t                  cmd_in;

    // class 1: TCP or UDP, first fragment, destination port matches
    assign hit = (in_ch.protocol == PROTO_TCP || in_ch.protocol == PROTO_UDP) &&
                 in_ch.first_fragment && (in_ch.dest_port == cfg.special_port);

    always_comb
    begin
        cmd_in.func     = in_ch.func;
        cmd_in.cls      = hit ? CLS_W'(1) : '0;
        cmd_in.now_time = in_ch.now_time;
        cmd_in.size     = in_ch.packet_size;
        cmd_in.tag      = in_ch.packet_tag;
    end

    assign in_ch.ready = (cnt_reg != CMDQ_CNT_W'(CMDQ_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign cmd_valid   = (cnt_reg != '0);
    assign cmd         = q_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 :
                              wr_ptr_reg + 1'b1;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 :
                              rd_ptr_reg + 1'b1;
            end
            if (push && !cmd_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (!push && cmd_pop)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end
endmodule

@@ design/wfq_back.sv @@
// ----------------------------------------------------------------------------
// WFQ back end
// Sequence enqueue (virtual clock, finish tag) and dequeue per command.
// ----------------------------------------------------------------------------
module wfq_back (
    input  logic          clk,
    input  logic          rst_n,
    input  wfq_pkg::cfg_t cfg,
    input  logic          cmd_valid,
    input  wfq_pkg::cmd_t cmd,
    output logic          cmd_pop,
    wfq_out_if.source     out_ch
);
    import wfq_pkg::*;

    bstate_t             state_reg, state_next;
    cmd_t                cmd_reg;
    logic [CLS_W-1:0]    idx_reg;
    logic [ITER_W-1:0]   iter_reg;
    logic                min_vld_reg;
    logic [CLS_W-1:0]    min_idx_reg;
    logic [TIME_W-1:0]   min_lf_reg;
    logic [PKT_W-1:0]    best_pkt_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [TIME_W-1:0]   vc_reg;
    logic [TIME_W-1:0]   rc_reg;
    logic [TIME_W-1:0]   lf_reg   [NUM_CLASSES];
    logic                busy_reg [NUM_CLASSES];
    logic [CNT_W-1:0]    cnt_reg  [NUM_CLASSES];
    logic [PTR_W-1:0]    head_reg [NUM_CLASSES];
    logic [PTR_W-1:0]    tail_reg [NUM_CLASSES];
    logic [TIME_W-1:0]   diff_reg;
    logic [MUL_P_W-1:0]  acc_reg;
    logic [MUL_P_W-1:0]  mul_p_reg;
    logic [P_W-1:0]      p_reg;

    status_t             res_status_reg;
    logic                res_cls_reg;
    logic [TAG_W-1:0]    res_tag_reg;
    logic [SIZE_W-1:0]   res_size_reg;
    logic [TIME_W-1:0]   res_fin_reg;

    logic [SUM_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic                div_start;
    logic [NUM_PW-1:0]   div_num;
    logic [DEN_W-1:0]    div_den;
    logic                div_done;
    logic [TIME_W-1:0]   div_q;
    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic [TIME_W-1:0]   lf_rd;
    logic                busy_rd;
    logic [CNT_W-1:0]    cnt_rd;
    logic [PTR_W-1:0]    head_rd;
    logic [PTR_W-1:0]    tail_rd;
    logic [WEIGHT_W-1:0] weight_rd;
    logic                drop;
    logic                last_cls;
    logic [TIME_W-1:0]   delta;
    logic [TIME_W-1:0]   vt;
    logic [TIME_W-1:0]   start_t;
    logic [TIME_W-1:0]   fin;
    logic [P_W-WEIGHT_FRAC-1:0] span_full;
    logic [TIME_W-1:0]   span;
    logic [TIME_W-1:0]   rd_fin;

    assign lf_rd     = lf_reg[idx_reg];
    assign busy_rd   = busy_reg[idx_reg];
    assign cnt_rd    = cnt_reg[idx_reg];
    assign head_rd   = head_reg[idx_reg];
    assign tail_rd   = tail_reg[idx_reg];
    assign weight_rd = (idx_reg == '0) ? cfg.first_weight : cfg.second_weight;
    assign last_cls  = (idx_reg == CLS_W'(NUM_CLASSES - 1));

    assign drop = (32'(cnt_rd) >= 32'(cfg.class_limit)) ||
                  (32'(cnt_rd) >= 32'(QUEUE_DEPTH));
    assign delta = (cmd_reg.now_time > rc_reg) ? cmd_reg.now_time - rc_reg : '0;
    assign vt      = sat_add(vc_reg, div_q);
    assign start_t = (lf_rd > vc_reg) ? lf_rd : vc_reg;
    assign fin     = sat_add(start_t, div_q);
    assign span_full = p_reg[P_W-1:WEIGHT_FRAC];
    assign span    = (|span_full[P_W-WEIGHT_FRAC-1:TIME_W]) ? '1 :
                     span_full[TIME_W-1:0];
    assign rd_fin  = ram_rdata[ENTRY_W-1:PKT_W];

    assign ram_waddr = slot_addr(idx_reg, tail_rd);
    assign ram_raddr = slot_addr(idx_reg, head_rd);
    assign ram_wdata = {fin, cmd_reg.size, cmd_reg.tag};

    wfq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wfq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        div_start  = 1'b0;
        div_num    = NUM_PW'(delta) << WEIGHT_FRAC;
        div_den    = DEN_W'(sum_reg);
        mul_a      = sum_reg;
        mul_b      = diff_reg[MUL_B_W-1:0];
        case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    state_next = cmd.func ? B_DQ_RD : B_EN_CHK;
                end
            end
            B_DQ_RD:
            begin
                ram_re     = 1'b1;
                state_next = B_DQ_CMP;
            end
            B_DQ_CMP:
            begin
                state_next = last_cls ? B_DQ_DONE : B_DQ_RD;
            end
            B_DQ_DONE:
            begin
                state_next = B_OUT;
            end
            B_EN_CHK:
            begin
                state_next = drop ? B_OUT : B_SCAN;
            end
            B_SCAN:
            begin
                state_next = last_cls ? B_ADV : B_SCAN;
            end
            B_ADV:
            begin
                if (min_vld_reg)
                begin
                    div_start  = 1'b1;
                    state_next = B_ADV_DIV;
                end
                else
                begin
                    state_next = B_DEN0;
                end
            end
            B_ADV_DIV:
            begin
                if (div_done)
                begin
                    state_next = (min_lf_reg <= vt) ? B_SPAN0 : B_DEN0;
                end
            end
            B_SPAN0:
            begin
                state_next = B_SPAN1;
            end
            B_SPAN1:
            begin
                mul_b      = diff_reg[TIME_W-1:MUL_B_W];
                state_next = B_SPAN2;
            end
            B_SPAN2:
            begin
                state_next = B_DEL;
            end
            B_DEL:
            begin
                state_next = (iter_reg == ITER_W'(NUM_CLASSES)) ? B_DEN0 : B_SCAN;
            end
            B_DEN0:
            begin
                mul_a      = SUM_W'(weight_rd);
                mul_b      = cfg.link_rate[MUL_B_W-1:0];
                state_next = B_DEN1;
            end
            B_DEN1:
            begin
                mul_a      = SUM_W'(weight_rd);
                mul_b      = MUL_B_W'(cfg.link_rate >> MUL_B_W);
                state_next = B_DEN2;
            end
            B_DEN2:
            begin
                state_next = B_INC;
            end
            B_INC:
            begin
                div_start  = 1'b1;
                div_num    = NUM_PW'(cmd_reg.size) << (SIZE_SHIFT + FRAC_BITS + WEIGHT_FRAC);
                div_den    = p_reg[DEN_W-1:0];
                state_next = B_INC_DIV;
            end
            B_INC_DIV:
            begin
                if (div_done)
                begin
                    ram_we     = 1'b1;
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // scheduler state, all zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= '0;
            rc_reg <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                lf_reg[i]   <= '0;
                busy_reg[i] <= 1'b0;
                cnt_reg[i]  <= '0;
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                B_DQ_DONE:
                begin
                    if (min_vld_reg)
                    begin
                        head_reg[min_idx_reg] <= ptr_inc(head_reg[min_idx_reg]);
                        cnt_reg[min_idx_reg]  <= cnt_reg[min_idx_reg] - 1'b1;
                    end
                end
                B_ADV:
                begin
                    if (!min_vld_reg)
                    begin
                        rc_reg <= cmd_reg.now_time;
                    end
                end
                B_ADV_DIV:
                begin
                    if (div_done && !(min_lf_reg <= vt))
                    begin
                        vc_reg <= vt;
                        rc_reg <= cmd_reg.now_time;
                    end
                end
                B_DEL:
                begin
                    rc_reg                <= sat_add(rc_reg, span);
                    vc_reg                <= min_lf_reg;
                    busy_reg[min_idx_reg] <= 1'b0;
                end
                B_INC_DIV:
                begin
                    if (div_done)
                    begin
                        lf_reg[idx_reg]   <= fin;
                        busy_reg[idx_reg] <= 1'b1;
                        tail_reg[idx_reg] <= ptr_inc(tail_rd);
                        cnt_reg[idx_reg]  <= cnt_rd + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // working registers of the sequencer
    always_ff @(posedge clk)
    begin
        mul_p_reg <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
        case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_reg     <= cmd;
                    idx_reg     <= cmd.func ? '0 : cmd.cls;
                    min_vld_reg <= 1'b0;
                end
            end
            B_DQ_CMP:
            begin
                if (cnt_rd != '0 && (!min_vld_reg || rd_fin < min_lf_reg))
                begin
                    min_vld_reg  <= 1'b1;
                    min_idx_reg  <= idx_reg;
                    min_lf_reg   <= rd_fin;
                    best_pkt_reg <= ram_rdata[PKT_W-1:0];
                end
                if (!last_cls)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            B_DQ_DONE:
            begin
                if (min_vld_reg)
                begin
                    res_status_reg <= ST_DEQ;
                    res_cls_reg    <= min_idx_reg[0];
                    res_tag_reg    <= best_pkt_reg[TAG_W-1:0];
                    res_size_reg   <= best_pkt_reg[PKT_W-1:TAG_W];
                    res_fin_reg    <= min_lf_reg;
                end
                else
                begin
                    res_status_reg <= ST_EMPTY;
                    res_cls_reg    <= 1'b0;
                    res_tag_reg    <= '0;
                    res_size_reg   <= '0;
                    res_fin_reg    <= '0;
                end
            end
            B_EN_CHK:
            begin
                if (drop)
                begin
                    res_status_reg <= ST_DROP;
                    res_cls_reg    <= cmd_reg.cls[0];
                    res_tag_reg    <= '0;
                    res_size_reg   <= '0;
                    res_fin_reg    <= '0;
                end
                iter_reg    <= '0;
                idx_reg     <= '0;
                min_vld_reg <= 1'b0;
                sum_reg     <= '0;
            end
            B_SCAN:
            begin
                if (busy_rd)
                begin
                    sum_reg <= sum_reg + SUM_W'(weight_rd);
                    if (!min_vld_reg || lf_rd < min_lf_reg)
                    begin
                        min_vld_reg <= 1'b1;
                        min_idx_reg <= idx_reg;
                        min_lf_reg  <= lf_rd;
                    end
                end
                if (!last_cls)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            B_ADV:
            begin
                if (!min_vld_reg)
                begin
                    idx_reg <= cmd_reg.cls;
                end
            end
            B_ADV_DIV:
            begin
                if (div_done)
                begin
                    diff_reg <= (min_lf_reg > vc_reg) ? min_lf_reg - vc_reg : '0;
                    if (!(min_lf_reg <= vt))
                    begin
                        idx_reg <= cmd_reg.cls;
                    end
                end
            end
            B_SPAN1, B_DEN1:
            begin
                acc_reg <= mul_p_reg;
            end
            B_SPAN2, B_DEN2:
            begin
                p_reg <= P_W'(acc_reg) + (P_W'(mul_p_reg) << MUL_B_W);
            end
            B_DEL:
            begin
                if (iter_reg == ITER_W'(NUM_CLASSES))
                begin
                    idx_reg <= cmd_reg.cls;
                end
                else
                begin
                    iter_reg    <= iter_reg + 1'b1;
                    idx_reg     <= '0;
                    min_vld_reg <= 1'b0;
                    sum_reg     <= '0;
                end
            end
            B_INC_DIV:
            begin
                if (div_done)
                begin
                    res_status_reg <= ST_ACCEPT;
                    res_cls_reg    <= cmd_reg.cls[0];
                    res_tag_reg    <= '0;
                    res_size_reg   <= '0;
                    res_fin_reg    <= fin;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_ch.valid       = (state_reg == B_OUT);
    assign out_ch.status      = res_status_reg;
    assign out_ch.class_index = res_cls_reg;
    assign out_ch.out_tag     = res_tag_reg;
    assign out_ch.out_size    = res_size_reg;
    assign out_ch.finish_tag  = res_fin_reg;
endmodule

@@ design/wfq_scheduler_virtual_time.sv @@
// ----------------------------------------------------------------------------
// WFQ scheduler with GPS virtual time
// Weighted fair queueing over per-class packet FIFOs with finish-tag order.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  ---------+-----+--------------------------------------------------------
//  in_ch    | in  | func, now_time, protocol, first_fragment, dest_port,
//           |     | packet_size, packet_tag
//  out_ch   | out | status, class_index, out_tag, out_size, finish_tag
//  cfg_ch   | in  | index, data (register write, always ready)
//
//  Dequeue reads each class head from the shared FIFO RAM in turn. Enqueue
//  picks up and checks the command, then each deleted class costs a rescan,
//  a divide to advance the virtual clock and a span product on the two-pass
//  multiplier; the closing pass rescans and, when a class stays busy, divides
//  once more, and the finish tag takes a product and a divide; a drop goes
//  straight to its result. One result per transaction; a two-entry command
//  queue keeps taking requests while a result waits. Reset is immediate, no
//  clearing pass: FIFO entries are used only after they are written.
// ----------------------------------------------------------------------------
`include "wfq_scheduler_virtual_time_macros.svh"

module wfq_scheduler_virtual_time (
    input  logic       clk,
    input  logic       rst_n,
    wfq_in_if.sink     in_ch,
    wfq_out_if.source  out_ch,
    wfq_cfg_if.sink    cfg_ch
);
    import wfq_pkg::*;

    logic [WEIGHT_W-1:0] first_weight_reg;
    logic [WEIGHT_W-1:0] second_weight_reg;
    logic [RATE_W-1:0]   link_rate_reg;
    logic [PORT_W-1:0]   special_port_reg;
    logic [LIMIT_W-1:0]  class_limit_reg;
    cfg_t                cfg;
    logic                cmd_valid;
    cmd_t                cmd;
    logic                cmd_pop;

    logic                res_valid;
    logic                res_empty;
    logic                res_drop;
    logic                res_accept;
    logic                res_stall;
    logic                empty_ok;
    logic                drop_ok;
    logic                accept_ok;
    logic [STATUS_W+TIME_W-1:0] res_bits;

    // register writes are taken in any cycle
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_weight_reg  <= RST_WEIGHT;
            second_weight_reg <= RST_WEIGHT;
            link_rate_reg     <= RST_RATE;
            special_port_reg  <= RST_PORT;
            class_limit_reg   <= RST_LIMIT;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                CFG_FIRST_WEIGHT:  first_weight_reg  <= cfg_ch.data[WEIGHT_W-1:0];
                CFG_SECOND_WEIGHT: second_weight_reg <= cfg_ch.data[WEIGHT_W-1:0];
                CFG_LINK_RATE:     link_rate_reg     <= cfg_ch.data[RATE_W-1:0];
                CFG_SPECIAL_PORT:  special_port_reg  <= cfg_ch.data[PORT_W-1:0];
                CFG_CLASS_LIMIT:   class_limit_reg   <= cfg_ch.data[LIMIT_W-1:0];
                default:
                begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.first_weight  = first_weight_reg;
        cfg.second_weight = second_weight_reg;
        cfg.link_rate     = link_rate_reg;
        cfg.special_port  = special_port_reg;
        cfg.class_limit   = class_limit_reg;
    end

    // front: accept, classify, queue
    wfq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // back: advance the virtual clock, tag, store and pick packets
    wfq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_ch    (out_ch)
    );

    // result classes and the fields each one must leave at zero
    assign res_valid  = out_ch.valid;
    assign res_empty  = out_ch.valid && out_ch.status == ST_EMPTY;
    assign res_drop   = out_ch.valid && out_ch.status == ST_DROP;
    assign res_accept = out_ch.valid && out_ch.status == ST_ACCEPT;
    assign res_stall  = out_ch.valid && !out_ch.ready;
    assign empty_ok   = out_ch.class_index == 1'b0 && out_ch.out_tag == '0 &&
                        out_ch.finish_tag == '0;
    assign drop_ok    = out_ch.finish_tag == '0 && out_ch.out_size == '0;
    assign accept_ok  = out_ch.out_tag == '0 && out_ch.out_size == '0;
    assign res_bits   = {out_ch.status, out_ch.finish_tag};

    // an empty result carries nothing
    `WFQ_ASSERT_IMPL(a_empty_zero, clk, rst_n, res_empty, empty_ok, "empty result not zero")
    // a drop reports no size and no finish time
    `WFQ_ASSERT_IMPL(a_drop_zero, clk, rst_n, res_drop, drop_ok, "dropped result not zero")
    // an accepted enqueue returns no descriptor
    `WFQ_ASSERT_IMPL(a_accept_zero, clk, rst_n, res_accept, accept_ok, "accept has descriptor")
    // a stalled result holds its payload
    `WFQ_ASSERT_NEXT(a_hold, clk, rst_n, res_stall, res_valid && $stable(res_bits), "not held")
endmodule
